[sv/mcct_pkg.sv]
// Package: item types, op and status codes, and constants for the compare timer.
`timescale 1ns / 1ps
`default_nettype none

package mcct_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ALLOC   = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_START   = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;

    localparam int         SHIFT_BITS    = 4;
    localparam int         PRESCALE_BITS = 9;
    localparam int         FIRED_BITS    = 8;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 4'd6;
    localparam logic [SHIFT_BITS-1:0] MAX_SHIFT   = 4'd9;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  channel;
        logic [31:0] duration;
        logic        single_shot;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  fired_mask;
        logic [1:0]  status;
        logic [2:0]  granted_channel;
        logic [31:0] counter_now;
    } t_out_item;

    typedef struct packed {
        logic       tick_step;
        logic       alloc;
        logic       release_ch;
        logic       start;
        logic       stop;
        logic [2:0] channel;
        logic       single_shot;
    } t_bank_cmd;

    typedef struct packed {
        logic [FIRED_BITS-1:0] fired_mask;
        logic [1:0]            status;
        logic [2:0]            granted;
    } t_bank_resp;

endpackage

`default_nettype wire

[sv/multi_channel_compare_timer.sv]
// Top level: input register, op decode, prescaler, channel bank and result register.
//
//  port group   dir  handshake                 carries
//  i_in_*       in   i_in_valid / o_in_stall   t_in_item (op, channel, duration, one-shot)
//  o_out_*      out  o_out_valid / i_out_stall t_out_item (fired, status, grant, counter)
//  i_cfg_*      in   i_cfg_valid / o_cfg_ready prescale shift, 4 bits
//
// One item per cycle unless the result stalls; each goes through input and result registers.
// All state updates for an item happen as it moves from the input
// register to the result register, so the next item sees them immediately.
// Synchronous active-low reset clears flags, prescaler and counter; no clearing pass.
// A stalled result holds the input register; o_in_stall rises only then.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_compare_timer import mcct_pkg::*; #(
    parameter int CHANNELS     = 8,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_item,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out_item                  o_out_item,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_cfg_valid,
    input  wire logic [SHIFT_BITS-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);

    logic                    r_in_v;
    t_in_item                r_in;
    logic                    r_out_v;
    t_out_item               r_out;
    logic                    out_blocked;
    logic                    advance;
    logic                    tick;
    logic                    step;
    logic [COUNTER_BITS-1:0] counter;
    logic [COUNTER_BITS-1:0] counter_next;
    t_bank_cmd               cmd;
    t_bank_resp              resp;
    t_out_item               n_out;

    assign out_blocked = r_out_v && i_out_stall;
    assign advance     = r_in_v && !out_blocked;
    assign o_in_stall  = r_in_v && out_blocked;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;
    assign tick        = advance && (r_in.op == OP_TICK);

    always_comb begin
        cmd.tick_step   = step;
        cmd.alloc       = advance && (r_in.op == OP_ALLOC);
        cmd.release_ch  = advance && (r_in.op == OP_RELEASE);
        cmd.start       = advance && (r_in.op == OP_START);
        cmd.stop        = advance && (r_in.op == OP_STOP);
        cmd.channel     = r_in.channel;
        cmd.single_shot = r_in.single_shot;
    end

    mcct_prescale #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_prescale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_tick         (tick),
        .o_step         (step),
        .o_counter      (counter),
        .o_counter_next (counter_next)
    );

    mcct_chan_bank #(
        .CHANNELS     (CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_bank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_duration     (r_in.duration),
        .i_counter      (counter),
        .i_counter_next (counter_next),
        .o_resp         (resp)
    );

    always_comb begin
        n_out.fired_mask      = resp.fired_mask;
        n_out.status          = resp.status;
        n_out.granted_channel = resp.granted;
        n_out.counter_now     = 32'(counter_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_v <= 1'b1;
            end else if (advance) begin
                r_in_v <= 1'b0;
            end
            if (advance) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[sv/mcct_prescale.sv]
// Prescaler, shared wrapping counter and the prescale shift register.
`timescale 1ns / 1ps
`default_nettype none

module mcct_prescale import mcct_pkg::*; #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [SHIFT_BITS-1:0]   i_cfg_data,
    input  wire logic                    i_tick,
    output logic                         o_step,
    output logic [COUNTER_BITS-1:0]      o_counter,
    output logic [COUNTER_BITS-1:0]      o_counter_next
);

    logic [SHIFT_BITS-1:0]    r_shift;
    logic [PRESCALE_BITS-1:0] r_pcount;
    logic [PRESCALE_BITS-1:0] n_pcount;
    logic [COUNTER_BITS-1:0]  r_counter;
    logic [SHIFT_BITS-1:0]    eff_shift;
    logic [PRESCALE_BITS:0]   limit;
    logic [PRESCALE_BITS:0]   pcount_inc;
    logic                     wrap;

    always_comb begin
        eff_shift  = (r_shift > MAX_SHIFT) ? MAX_SHIFT : r_shift;
        limit      = (PRESCALE_BITS+1)'(1) << eff_shift;
        pcount_inc = {1'b0, r_pcount} + (PRESCALE_BITS+1)'(1);
        wrap       = pcount_inc >= limit;
        o_step     = i_tick && wrap;
        n_pcount   = r_pcount;
        if (i_tick) begin
            n_pcount = wrap ? '0 : pcount_inc[PRESCALE_BITS-1:0];
        end
        o_counter      = r_counter;
        o_counter_next = o_step ? r_counter + COUNTER_BITS'(1) : r_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= SHIFT_RESET;
            r_pcount  <= '0;
            r_counter <= '0;
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_data;
            end
            r_pcount  <= n_pcount;
            r_counter <= o_counter_next;
        end
    end

endmodule

`default_nettype wire

[sv/mcct_chan_bank.sv]
// Channel bank: per-channel compare state, allocation, arming and fire detection.
`timescale 1ns / 1ps
`default_nettype none

module mcct_chan_bank import mcct_pkg::*; #(
    parameter int CHANNELS     = 8,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_bank_cmd               i_cmd,
    input  wire logic [31:0]             i_duration,
    input  wire logic [COUNTER_BITS-1:0] i_counter,
    input  wire logic [COUNTER_BITS-1:0] i_counter_next,
    output t_bank_resp                   o_resp
);

    logic [COUNTER_BITS-1:0] r_cmp    [CHANNELS];
    logic [COUNTER_BITS-1:0] r_period [CHANNELS];
    logic [CHANNELS-1:0]     r_alloc, n_alloc;
    logic [CHANNELS-1:0]     r_armed, n_armed;
    logic [CHANNELS-1:0]     r_oneshot, n_oneshot;
    logic [CHANNELS-1:0]     sel;
    logic [CHANNELS-1:0]     hit;
    logic [CHANNELS-1:0]     free;
    logic [CHANNELS-1:0]     grant;
    logic [FIRED_BITS-1:0]   fired;
    logic [COUNTER_BITS-1:0] dur_m;
    logic                    dur_zero;
    logic                    ch_ok;
    logic                    start_ok;
    logic                    ctl_ok;
    logic [2:0]              grant_idx;

    assign dur_m    = i_duration[COUNTER_BITS-1:0];
    assign dur_zero = (dur_m == '0);
    assign free     = ~r_alloc;
    assign grant    = free & (~free + CHANNELS'(1));
    assign ch_ok    = |(sel & r_alloc);
    assign start_ok = i_cmd.start && ch_ok && !dur_zero;
    assign ctl_ok   = (i_cmd.release_ch || i_cmd.stop) && ch_ok;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        assign sel[i] = (int'(i_cmd.channel) == i);
        assign hit[i] = i_cmd.tick_step && r_armed[i] && (r_cmp[i] == i_counter_next);

        always_ff @(posedge i_clk) begin
            if (start_ok && sel[i]) begin
                r_cmp[i]    <= i_counter + dur_m;
                r_period[i] <= dur_m;
            end else if (hit[i] && !r_oneshot[i]) begin
                r_cmp[i] <= r_cmp[i] + r_period[i];
            end
        end
    end

    for (genvar j = 0; j < FIRED_BITS; j++) begin : g_fired
        if (j < CHANNELS) begin : g_used
            assign fired[j] = hit[j];
        end else begin : g_unused
            assign fired[j] = 1'b0;
        end
    end

    always_comb begin
        n_alloc   = r_alloc;
        n_armed   = r_armed;
        n_oneshot = r_oneshot;
        for (int i = 0; i < CHANNELS; i++) begin
            if (hit[i] && r_oneshot[i]) begin
                n_armed[i] = 1'b0;
            end
            if (i_cmd.alloc && grant[i]) begin
                n_alloc[i]   = 1'b1;
                n_armed[i]   = 1'b0;
                n_oneshot[i] = 1'b0;
            end
            if (ctl_ok && sel[i]) begin
                n_armed[i]   = 1'b0;
                n_oneshot[i] = 1'b0;
                if (i_cmd.release_ch) begin
                    n_alloc[i] = 1'b0;
                end
            end
            if (start_ok && sel[i]) begin
                n_armed[i]   = 1'b1;
                n_oneshot[i] = i_cmd.single_shot;
            end
        end
    end

    always_comb begin
        grant_idx = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (grant[i]) begin
                grant_idx = grant_idx | 3'(i);
            end
        end
        o_resp.fired_mask = fired;
        o_resp.granted    = i_cmd.alloc ? grant_idx : 3'd0;
        priority if (i_cmd.alloc && !(|free)) begin
            o_resp.status = ST_NO_FREE;
        end else if ((i_cmd.release_ch || i_cmd.stop) && !ch_ok) begin
            o_resp.status = ST_REJECT;
        end else if (i_cmd.start && (!ch_ok || dur_zero)) begin
            o_resp.status = ST_REJECT;
        end else begin
            o_resp.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc   <= '0;
            r_armed   <= '0;
            r_oneshot <= '0;
        end else begin
            r_alloc   <= n_alloc;
            r_armed   <= n_armed;
            r_oneshot <= n_oneshot;
        end
    end

endmodule

`default_nettype wire

[sv/mcct_checker.sv]
// Port-level checker for the compare timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcct_checker import mcct_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      o_in_stall,
    input  wire logic      o_out_valid,
    input  wire t_out_item o_out_item,
    input  wire logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |->
            o_out_item.fired_mask == 8'd0 && o_out_item.granted_channel == 3'd0)
        else $error("failed item reports fire or grant");

    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid
            || o_out_item.counter_now == $past(o_out_item.counter_now)
            || o_out_item.counter_now == $past(o_out_item.counter_now) + 32'd1
            || o_out_item.counter_now == 32'd0)
        else $error("counter jumped between items");

endmodule

bind multi_channel_compare_timer mcct_checker u_mcct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for multi_channel_compare_timer: table items checked by hand or model, random items by model.
`timescale 1ns / 1ps

module tb;
    import mcct_pkg::*;

    localparam int N_CH        = 8;
    localparam int CNT_BITS    = 32;
    localparam int DIR_ROWS    = 25;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 4;
    localparam int MAX_PRINTS  = 40;

    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam logic [SHIFT_BITS-1:0] SHIFT_FASTEST = 4'd0;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MID     = 4'd2;
    localparam logic [SHIFT_BITS-1:0] SHIFT_TOP     = 4'hF;

    localparam logic BY_HAND  = 1'b1;
    localparam logic BY_MODEL = 1'b0;
    localparam t_out_item NO_WANT = '0;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_LONG,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        t_in_item  stim;
        logic      by_hand;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [SHIFT_BITS-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  o_cfg_ready;

    // timer model state
    logic [SHIFT_BITS-1:0]    m_shift;
    logic [PRESCALE_BITS-1:0] m_pscount;
    logic [CNT_BITS-1:0]      m_counter;
    logic [CNT_BITS-1:0]      m_compare [N_CH];
    logic [CNT_BITS-1:0]      m_period  [N_CH];
    logic [N_CH-1:0]          m_alloc;
    logic [N_CH-1:0]          m_armed;
    logic [N_CH-1:0]          m_oneshot;

    t_out_item   pending_results [$];
    t_out_item   oldest_result;
    t_dir_row    dir_table [DIR_ROWS];
    t_stall_mode stall_mode  = STALL_NONE;
    logic [5:0]  stall_phase = '0;
    int          stuck_cycles = 0;
    int          n_errors     = 0;
    int          n_items      = 0;
    int          n_results    = 0;
    int          n_fired      = 0;
    int          n_reject     = 0;
    int          n_no_free    = 0;

    multi_channel_compare_timer #(
        .CHANNELS     (N_CH),
        .COUNTER_BITS (CNT_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void reset_timer_model();
        m_shift   = SHIFT_RESET;
        m_pscount = '0;
        m_counter = '0;
        m_alloc   = '0;
        m_armed   = '0;
        m_oneshot = '0;
        for (int c = 0; c < N_CH; c++) begin
            m_compare[c] = '0;
            m_period[c]  = '0;
        end
    endfunction

    function automatic t_out_item timer_result(t_in_item it);
        t_out_item             r;
        logic [SHIFT_BITS-1:0] sh;
        logic [9:0]            lim;
        logic                  owned;
        r = '0;
        owned = m_alloc[it.channel];
        case (it.op)
            OP_TICK: begin
                sh  = (m_shift > MAX_SHIFT) ? MAX_SHIFT : m_shift;
                lim = 10'd1 << sh;
                if ({1'b0, m_pscount} + 10'd1 >= lim) begin
                    m_pscount = '0;
                    m_counter = m_counter + 1'b1;
                    for (int c = 0; c < N_CH; c++) begin
                        if (m_armed[c] && m_compare[c] == m_counter) begin
                            r.fired_mask[c] = 1'b1;
                            if (m_oneshot[c]) begin
                                m_armed[c] = 1'b0;
                            end else begin
                                m_compare[c] = m_compare[c] + m_period[c];
                            end
                        end
                    end
                end else begin
                    m_pscount = m_pscount + 1'b1;
                end
            end
            OP_ALLOC: begin
                r.status = ST_NO_FREE;
                for (int c = 0; c < N_CH; c++) begin
                    if (r.status == ST_NO_FREE && !m_alloc[c]) begin
                        m_alloc[c]        = 1'b1;
                        m_armed[c]        = 1'b0;
                        m_oneshot[c]      = 1'b0;
                        r.granted_channel = 3'(c);
                        r.status          = ST_OK;
                    end
                end
            end
            OP_RELEASE, OP_STOP: begin
                if (!owned) begin
                    r.status = ST_REJECT;
                end else begin
                    m_armed[it.channel]   = 1'b0;
                    m_oneshot[it.channel] = 1'b0;
                    if (it.op == OP_RELEASE) begin
                        m_alloc[it.channel] = 1'b0;
                    end
                end
            end
            OP_START: begin
                if (!owned || it.duration == '0) begin
                    r.status = ST_REJECT;
                end else begin
                    m_compare[it.channel] = m_counter + it.duration;
                    m_period[it.channel]  = it.duration;
                    m_oneshot[it.channel] = it.single_shot;
                    m_armed[it.channel]   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.counter_now = m_counter;
        return r;
    endfunction

    // mostly well-formed traffic on owned channels, with some noise
    function automatic t_in_item pick_timer_op(int tick_pct);
        t_in_item   it;
        int         roll;
        logic [2:0] owned [$];
        it             = '0;
        it.channel     = 3'($urandom_range(0, 7));
        it.single_shot = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       it.duration = $urandom;
            1:       it.duration = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
            default: it.duration = 32'($urandom_range(1, 48));
        endcase
        for (int c = 0; c < N_CH; c++) begin
            if (m_alloc[c]) begin
                owned.push_back(3'(c));
            end
        end
        if (owned.size() != 0 && $urandom_range(0, 3) != 0) begin
            it.channel = owned[$urandom_range(0, owned.size() - 1)];
        end
        roll = $urandom_range(0, 99);
        if (roll < tick_pct) begin
            it.op = OP_TICK;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                it.op = OP_START;
            end else if (roll < 44) begin
                it.op       = OP_START;
                it.duration = '0;
            end else if (roll < 62) begin
                it.op = OP_ALLOC;
            end else if (roll < 75) begin
                it.op = OP_STOP;
            end else if (roll < 88) begin
                it.op = OP_RELEASE;
            end else if (roll < 94) begin
                it.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            end else begin
                it.op = OP_START;
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("MISMATCH %s at result %0d: got 0x%0h want 0x%0h",
                     field, n_results, got, want);
        end
    endtask

    task automatic send_item(t_in_item it, logic by_hand, t_out_item want);
        t_out_item pred;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pred = timer_result(it);
        pending_results.push_back(by_hand ? want : pred);
        n_items++;
    endtask

    task automatic run_random(int n_req, int tick_pct);
        int done;
        int burst;
        int gap;
        done = 0;
        while (done < n_req) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && done < n_req; b++) begin
                send_item(pick_timer_op(tick_pct), BY_MODEL, NO_WANT);
                done++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_prescale(logic [SHIFT_BITS-1:0] shift);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= shift;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        m_shift = shift;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase == '0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_SPARSE: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_LONG:   i_out_stall <= (stall_phase[2:0] < 3'd5);
            default:      i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_item.counter_now, '0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_out_item.fired_mask !== oldest_result.fired_mask)
                    report_mismatch("fired_mask", 32'(o_out_item.fired_mask),
                                    32'(oldest_result.fired_mask));
                if (o_out_item.status !== oldest_result.status)
                    report_mismatch("status", 32'(o_out_item.status),
                                    32'(oldest_result.status));
                if (o_out_item.granted_channel !== oldest_result.granted_channel)
                    report_mismatch("granted_channel", 32'(o_out_item.granted_channel),
                                    32'(oldest_result.granted_channel));
                if (o_out_item.counter_now !== oldest_result.counter_now)
                    report_mismatch("counter_now", o_out_item.counter_now,
                                    oldest_result.counter_now);
            end
            n_results++;
            n_fired += $countones(o_out_item.fired_mask);
            if (o_out_item.status == ST_REJECT) n_reject++;
            if (o_out_item.status == ST_NO_FREE) n_no_free++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no progress for %0d cycles", STUCK_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        //  op          ch     duration        one    check     fired  status      grant  counter
        dir_table = '{
            {OP_TICK,    3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_RELEASE, 3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_REJECT,  3'd0,  32'd0},
            {OP_START,   3'd3, 32'd5,          1'b1,  BY_HAND,  8'h00, ST_REJECT,  3'd0,  32'd0},
            {OP_STOP,    3'd7, 32'hFFFF_FFFF,  1'b1,  BY_HAND,  8'h00, ST_REJECT,  3'd0,  32'd0},
            {OP_RSVD_LO, 3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_RSVD_HI, 3'd7, 32'hFFFF_FFFF,  1'b1,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_ALLOC,   3'd5, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd1,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd2,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd3,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd4,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd5,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd6,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd7,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_NO_FREE, 3'd0,  32'd0},
            {OP_START,   3'd0, 32'd0,          1'b1,  BY_HAND,  8'h00, ST_REJECT,  3'd0,  32'd0},
            {OP_START,   3'd0, 32'd1,          1'b1,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_START,   3'd7, 32'hFFFF_FFFF,  1'b0,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_START,   3'd0, 32'd2,          1'b0,  BY_MODEL, NO_WANT},
            {OP_STOP,    3'd7, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_RELEASE, 3'd3, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd0,  32'd0},
            {OP_ALLOC,   3'd0, 32'd0,          1'b0,  BY_HAND,  8'h00, ST_OK,      3'd3,  32'd0},
            {OP_START,   3'd3, 32'h8000_0000,  1'b1,  BY_MODEL, NO_WANT},
            {OP_TICK,    3'd2, 32'h7FFF_FFFF,  1'b1,  BY_MODEL, NO_WANT},
            {OP_RELEASE, 3'd3, 32'd0,          1'b0,  BY_MODEL, NO_WANT}
        };
        reset_timer_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_table[r].stim, dir_table[r].by_hand, dir_table[r].want);
        end

        drain_results();
        write_prescale(SHIFT_FASTEST);
        run_random(300, 55);
        drain_results();
        run_random(200, 60);
        drain_results();
        write_prescale(SHIFT_TOP);
        run_random(300, 96);
        drain_results();
        write_prescale(MAX_SHIFT);
        run_random(250, 96);
        // prescaler is part way through a long count here
        drain_results();
        write_prescale(SHIFT_FASTEST);
        run_random(150, 60);
        drain_results();
        write_prescale(SHIFT_MID);
        run_random(150, 75);
        drain_results();

        if (pending_results.size() != 0) begin
            report_mismatch("results never seen", pending_results.size(), '0);
        end
        $display("Ran %0d items (%0d from the table) over prescale shifts 6, 0, 15, 9, 0, 2",
                 n_items, DIR_ROWS);
        $display("Saw %0d results: %0d channel fires, %0d rejects, %0d allocs refused",
                 n_results, n_fired, n_reject, n_no_free);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mcct_pkg.sv
sv/mcct_prescale.sv
sv/mcct_chan_bank.sv
sv/multi_channel_compare_timer.sv
sv/mcct_checker.sv
tb/sv/tb.sv
